[sv/brd_pkg.sv]
// Shared widths, constants, register indexes and control types of the breath region detector.
`default_nettype none

package brd_pkg;

  localparam int unsigned DB_W       = 16;
  localparam int unsigned Q16_W      = 17;
  localparam int unsigned OUT_IDX_W  = 24;
  localparam int unsigned LSUM_W     = 40;
  localparam int unsigned FSUM_W     = 41;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [Q16_W-1:0]        ONE_Q16     = 17'd65536;
  localparam logic signed [DB_W-1:0]  PEAK_FLOOR  = -16'sd30720;
  localparam logic signed [DB_W-1:0]  NOISE_FLOOR = -16'sd15360;
  localparam logic signed [DB_W:0]    HYST_STEP   = 17'sd768;
  localparam logic signed [DB_W-1:0]  MEAN_DB_MAX = 16'sh7FFF;
  localparam logic signed [DB_W-1:0]  MEAN_DB_MIN = 16'sh8000;

  localparam logic [CFG_ADDR_W-1:0] REG_ENTER_THR = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FLAT_THR  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SENS      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_DUR   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MERGE_GAP = 3'd4;

  localparam logic signed [DB_W-1:0]   RST_ENTER_THR = -16'sd10240;
  localparam logic [Q16_W-1:0]         RST_FLAT_THR  = 17'd32768;
  localparam logic [Q16_W-1:0]         RST_SENS      = 17'd65536;
  localparam logic [OUT_IDX_W-1:0]     RST_MIN_DUR   = 24'd2400;
  localparam logic [OUT_IDX_W-1:0]     RST_MERGE_GAP = 24'd1440;

  typedef struct packed {
    logic load;
    logic weigh;
    logic decide;
    logic len_calc;
    logic div_start;
    logic mean;
    logic update;
    logic flush;
  } brd_cmd_t;

  typedef struct packed {
    logic close_pend;
    logic too_short;
    logic div_done;
    logic held_valid;
    logic merge;
    logic out_full;
    logic last;
  } brd_sts_t;

endpackage

`default_nettype wire

[sv/breath_region_detector.sv]
// Top level of the breath region detector: controller plus datapath.
//
//   channel | direction | handshake                | payload
//   cfg     | in        | cfg_we_i                 | cfg_addr_i, cfg_wdata_i
//   in      | in        | in_valid_i / in_ready_o  | env_db_i, flatness_i, buffer_end_i
//   out     | out       | out_valid_o / out_ready_i| region_valid_o .. last_of_buffer_o
//
// Load, weigh, decide, length, compare and finish states run per item when no region closes.
// A closing region not too short adds the 41-step restoring divider, mean and update states.
// A push waits while the one-entry result register is still full.
// Reset leaves the block idle with all region state cleared; no clearing pass.
`default_nettype none

module breath_region_detector #(
  parameter int unsigned INDEX_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [brd_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [brd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [brd_pkg::DB_W-1:0]      env_db_i,
  input  logic [brd_pkg::Q16_W-1:0]            flatness_i,
  input  logic                                 buffer_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 region_valid_o,
  output logic [brd_pkg::OUT_IDX_W-1:0]        start_sample_o,
  output logic [brd_pkg::OUT_IDX_W-1:0]        end_sample_o,
  output logic signed [brd_pkg::DB_W-1:0]      peak_db_o,
  output logic signed [brd_pkg::DB_W-1:0]      mean_db_o,
  output logic [brd_pkg::Q16_W-1:0]            mean_flatness_o,
  output logic                                 last_of_buffer_o
);
  import brd_pkg::*;

  brd_cmd_t cmd;
  brd_sts_t sts;

  brd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  brd_dpath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .env_db_i         (env_db_i),
    .flatness_i       (flatness_i),
    .buffer_end_i     (buffer_end_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .region_valid_o   (region_valid_o),
    .start_sample_o   (start_sample_o),
    .end_sample_o     (end_sample_o),
    .peak_db_o        (peak_db_o),
    .mean_db_o        (mean_db_o),
    .mean_flatness_o  (mean_flatness_o),
    .last_of_buffer_o (last_of_buffer_o)
  );

endmodule

`default_nettype wire

[sv/brd_div.sv]
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
`default_nettype none

module brd_div #(
  parameter int unsigned DVD_W = 41,
  parameter int unsigned DVS_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dvd_a_i,
  input  logic [DVD_W-1:0] dvd_b_i,
  input  logic [DVS_W-1:0] dvs_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quo_a_o,
  output logic [DVD_W-1:0] quo_b_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_a_q, rem_b_q, rem_a_d, rem_b_d;
  logic [DVD_W-1:0] quo_a_q, quo_b_q, quo_a_d, quo_b_d;
  logic [DVS_W:0]   sh_a, sh_b, dif_a, dif_b;
  logic             ge_a, ge_b;

  always_comb begin
    sh_a    = {rem_a_q, quo_a_q[DVD_W-1]};
    sh_b    = {rem_b_q, quo_b_q[DVD_W-1]};
    dif_a   = sh_a - {1'b0, dvs_q};
    dif_b   = sh_b - {1'b0, dvs_q};
    ge_a    = sh_a >= {1'b0, dvs_q};
    ge_b    = sh_b >= {1'b0, dvs_q};
    rem_a_d = ge_a ? dif_a[DVS_W-1:0] : sh_a[DVS_W-1:0];
    rem_b_d = ge_b ? dif_b[DVS_W-1:0] : sh_b[DVS_W-1:0];
    quo_a_d = {quo_a_q[DVD_W-2:0], ge_a};
    quo_b_d = {quo_b_q[DVD_W-2:0], ge_b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q   <= dvs_i;
      rem_a_q <= '0;
      rem_b_q <= '0;
      quo_a_q <= dvd_a_i;
      quo_b_q <= dvd_b_i;
    end else if (busy_q) begin
      rem_a_q <= rem_a_d;
      rem_b_q <= rem_b_d;
      quo_a_q <= quo_a_d;
      quo_b_q <= quo_b_d;
    end
  end

  assign done_o  = done_q;
  assign quo_a_o = quo_a_q;
  assign quo_b_o = quo_b_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("divider done without a finished run");
`endif

endmodule

`default_nettype wire

[sv/brd_dpath.sv]
// Datapath: registers, flatness weighting, hysteresis decision, sums, region hold and result register.
`default_nettype none

module brd_dpath #(
  parameter int unsigned INDEX_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [brd_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [brd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic signed [brd_pkg::DB_W-1:0]      env_db_i,
  input  logic [brd_pkg::Q16_W-1:0]            flatness_i,
  input  logic                                 buffer_end_i,
  input  brd_pkg::brd_cmd_t                    cmd_i,
  output brd_pkg::brd_sts_t                    sts_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic                                 region_valid_o,
  output logic [brd_pkg::OUT_IDX_W-1:0]        start_sample_o,
  output logic [brd_pkg::OUT_IDX_W-1:0]        end_sample_o,
  output logic signed [brd_pkg::DB_W-1:0]      peak_db_o,
  output logic signed [brd_pkg::DB_W-1:0]      mean_db_o,
  output logic [brd_pkg::Q16_W-1:0]            mean_flatness_o,
  output logic                                 last_of_buffer_o
);
  import brd_pkg::*;

  localparam int unsigned GAP_W = (INDEX_BITS > OUT_IDX_W) ? INDEX_BITS : OUT_IDX_W;
  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

  // configuration
  logic signed [DB_W-1:0] enter_thr_q;
  logic [Q16_W-1:0]       flat_thr_q, sens_q;
  logic [OUT_IDX_W-1:0]   min_dur_q, merge_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_thr_q <= RST_ENTER_THR;
      flat_thr_q  <= RST_FLAT_THR;
      sens_q      <= RST_SENS;
      min_dur_q   <= RST_MIN_DUR;
      merge_gap_q <= RST_MERGE_GAP;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ENTER_THR: enter_thr_q <= cfg_wdata_i[DB_W-1:0];
        REG_FLAT_THR:  flat_thr_q  <= cfg_wdata_i[Q16_W-1:0];
        REG_SENS:      sens_q      <= cfg_wdata_i[Q16_W-1:0];
        REG_MIN_DUR:   min_dur_q   <= cfg_wdata_i[OUT_IDX_W-1:0];
        REG_MERGE_GAP: merge_gap_q <= cfg_wdata_i[OUT_IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // input item and weighted flatness
  logic signed [DB_W-1:0] env_q;
  logic [Q16_W-1:0]       flat_q, w_q, s_eff;
  logic                   last_q;
  logic [2*Q16_W-1:0]     prod, wsum;

  always_comb begin
    s_eff = (sens_q > ONE_Q16) ? ONE_Q16 : sens_q;
    prod  = flat_q * s_eff;
    wsum  = prod + {2'b00, ONE_Q16 - s_eff, 15'b0};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      env_q  <= env_db_i;
      flat_q <= (flatness_i > ONE_Q16) ? ONE_Q16 : flatness_i;
      last_q <= buffer_end_i;
    end
    if (cmd_i.weigh) begin
      w_q <= wsum[Q16_W+15:16];
    end
  end

  // running region state
  logic                    in_breath_q, close_pend_q;
  logic [INDEX_BITS-1:0]   cnt_q, begin_q, close_end_q, len_q, idx_next;
  logic signed [DB_W-1:0]  peak_q, peak_base, peak_new;
  logic [LSUM_W-1:0]       lsum_q, lsum_base, lsum_sat;
  logic [FSUM_W-1:0]       fsum_q, fsum_base, fsum_sat;
  logic [LSUM_W:0]         lsum_add;
  logic [FSUM_W:0]         fsum_add;
  logic signed [DB_W:0]    thr_hi, env_ext;
  logic                    enter_ok, exit_ok, breath_nxt, exiting;

  always_comb begin
    env_ext    = {env_q[DB_W-1], env_q};
    thr_hi     = $signed({enter_thr_q[DB_W-1], enter_thr_q}) + HYST_STEP;
    enter_ok   = (env_q < enter_thr_q) && (env_q > NOISE_FLOOR) && (w_q > flat_thr_q);
    exit_ok    = (env_ext >= thr_hi) || (w_q <= flat_thr_q);
    breath_nxt = in_breath_q ? !exit_ok : enter_ok;
    exiting    = in_breath_q && exit_ok;
    idx_next   = (cnt_q == IDX_MAX) ? cnt_q : cnt_q + 1'b1;
    peak_base  = in_breath_q ? peak_q : PEAK_FLOOR;
    peak_new   = (env_q > peak_base) ? env_q : peak_base;
    lsum_base  = in_breath_q ? lsum_q : '0;
    fsum_base  = in_breath_q ? fsum_q : '0;
    lsum_add   = {lsum_base[LSUM_W-1], lsum_base} + (LSUM_W+1)'(env_q);
    if (lsum_add[LSUM_W] != lsum_add[LSUM_W-1]) begin
      lsum_sat = lsum_add[LSUM_W] ? {1'b1, {(LSUM_W-1){1'b0}}} : {1'b0, {(LSUM_W-1){1'b1}}};
    end else begin
      lsum_sat = lsum_add[LSUM_W-1:0];
    end
    fsum_add = {1'b0, fsum_base} + (FSUM_W+1)'(w_q);
    fsum_sat = fsum_add[FSUM_W] ? '1 : fsum_add[FSUM_W-1:0];
  end

  // divide
  logic [FSUM_W-1:0] lsum_ext, lmag, quo_l, quo_f;
  logic              div_done;

  assign lsum_ext = {lsum_q[LSUM_W-1], lsum_q};
  assign lmag     = lsum_q[LSUM_W-1] ? (~lsum_ext + 1'b1) : lsum_ext;

  brd_div #(
    .DVD_W (FSUM_W),
    .DVS_W (INDEX_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_a_i (lmag),
    .dvd_b_i (fsum_q),
    .dvs_i   (len_q),
    .done_o  (div_done),
    .quo_a_o (quo_l),
    .quo_b_o (quo_f)
  );

  // held region
  logic                   held_valid_q;
  logic [INDEX_BITS-1:0]  held_begin_q, held_finish_q;
  logic signed [DB_W-1:0] held_peak_q, held_mdb_q;
  logic [Q16_W-1:0]       held_mflat_q;

  // means and merge test
  logic signed [DB_W-1:0] mdb_q, mdb_d;
  logic [Q16_W-1:0]       mflat_q, mflat_d;
  logic                   merge_q, len_zero, too_short;
  logic [INDEX_BITS-1:0]  gap;

  always_comb begin
    len_zero  = (len_q == '0);
    too_short = GAP_W'(len_q) < GAP_W'(min_dur_q);
    gap       = (begin_q >= held_finish_q) ? begin_q - held_finish_q : '0;
    if (len_zero) begin
      mdb_d = '0;
    end else if (!lsum_q[LSUM_W-1]) begin
      mdb_d = (quo_l > FSUM_W'(MEAN_DB_MAX)) ? MEAN_DB_MAX : quo_l[DB_W-1:0];
    end else begin
      mdb_d = (quo_l > FSUM_W'(ONE_Q16 >> 1)) ? MEAN_DB_MIN : (~quo_l[DB_W-1:0] + 1'b1);
    end
    if (len_zero) begin
      mflat_d = '0;
    end else begin
      mflat_d = (quo_f > FSUM_W'(ONE_Q16)) ? ONE_Q16 : quo_f[Q16_W-1:0];
    end
  end

  // result register
  logic [DB_W:0]          hm_db_sum;
  logic [Q16_W:0]         hm_fl_sum;
  logic                   push, merging;

  logic                   out_valid_q, out_region_q, out_last_q;
  logic [OUT_IDX_W-1:0]   out_start_q, out_end_q;
  logic signed [DB_W-1:0] out_peak_q, out_mdb_q;
  logic [Q16_W-1:0]       out_mflat_q;

  always_comb begin
    hm_db_sum = {held_mdb_q[DB_W-1], held_mdb_q} + {mdb_q[DB_W-1], mdb_q};
    hm_fl_sum = {1'b0, held_mflat_q} + {1'b0, mflat_q};
    merging   = held_valid_q && merge_q;
    push      = cmd_i.flush || (cmd_i.update && held_valid_q && !merge_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_breath_q   <= 1'b0;
      close_pend_q  <= 1'b0;
      cnt_q         <= '0;
      begin_q       <= '0;
      close_end_q   <= '0;
      len_q         <= '0;
      peak_q        <= PEAK_FLOOR;
      lsum_q        <= '0;
      fsum_q        <= '0;
      mdb_q         <= '0;
      mflat_q       <= '0;
      merge_q       <= 1'b0;
      held_valid_q  <= 1'b0;
      held_begin_q  <= '0;
      held_finish_q <= '0;
      held_peak_q   <= '0;
      held_mdb_q    <= '0;
      held_mflat_q  <= '0;
    end else begin
      if (cmd_i.decide) begin
        in_breath_q  <= breath_nxt;
        cnt_q        <= idx_next;
        close_pend_q <= exiting || (breath_nxt && last_q);
        close_end_q  <= exiting ? cnt_q : idx_next;
        if (!in_breath_q && enter_ok) begin
          begin_q <= cnt_q;
        end
        if (breath_nxt) begin
          peak_q <= peak_new;
          lsum_q <= lsum_sat;
          fsum_q <= fsum_sat;
        end
      end
      if (cmd_i.len_calc) begin
        len_q <= (close_end_q >= begin_q) ? close_end_q - begin_q : '0;
      end
      if (cmd_i.mean) begin
        mdb_q   <= mdb_d;
        mflat_q <= mflat_d;
        merge_q <= GAP_W'(gap) <= GAP_W'(merge_gap_q);
      end
      if (cmd_i.update) begin
        held_finish_q <= close_end_q;
        if (merging) begin
          if (peak_q > held_peak_q) begin
            held_peak_q <= peak_q;
          end
          held_mdb_q   <= hm_db_sum[DB_W:1];
          held_mflat_q <= hm_fl_sum[Q16_W:1];
        end else begin
          held_valid_q <= 1'b1;
          held_begin_q <= begin_q;
          held_peak_q  <= peak_q;
          held_mdb_q   <= mdb_q;
          held_mflat_q <= mflat_q;
        end
      end
      if (cmd_i.flush) begin
        in_breath_q   <= 1'b0;
        cnt_q         <= '0;
        begin_q       <= '0;
        peak_q        <= PEAK_FLOOR;
        lsum_q        <= '0;
        fsum_q        <= '0;
        held_valid_q  <= 1'b0;
        held_begin_q  <= '0;
        held_finish_q <= '0;
        held_peak_q   <= '0;
        held_mdb_q    <= '0;
        held_mflat_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_region_q <= held_valid_q;
      out_last_q   <= cmd_i.flush;
      out_start_q  <= held_valid_q ? OUT_IDX_W'(held_begin_q) : '0;
      out_end_q    <= held_valid_q ? OUT_IDX_W'(held_finish_q) : '0;
      out_peak_q   <= held_valid_q ? held_peak_q : '0;
      out_mdb_q    <= held_valid_q ? held_mdb_q : '0;
      out_mflat_q  <= held_valid_q ? held_mflat_q : '0;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.close_pend = close_pend_q;
    sts_o.too_short  = too_short;
    sts_o.div_done   = div_done;
    sts_o.held_valid = held_valid_q;
    sts_o.merge      = merge_q;
    sts_o.out_full   = out_valid_q;
    sts_o.last       = last_q;
  end

  assign out_valid_o      = out_valid_q;
  assign region_valid_o   = out_region_q;
  assign start_sample_o   = out_start_q;
  assign end_sample_o     = out_end_q;
  assign peak_db_o        = out_peak_q;
  assign mean_db_o        = out_mdb_q;
  assign mean_flatness_o  = out_mflat_q;
  assign last_of_buffer_o = out_last_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !out_valid_q)
    else $error("result register overwritten while full");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> (!held_valid_q && !in_breath_q && cnt_q == '0))
    else $error("state not cleared after buffer end");

  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_region_q) |-> out_last_q)
    else $error("empty end marker not flagged last of buffer");
`endif

endmodule

`default_nettype wire

[sv/brd_ctrl.sv]
// Controller: sequences one item through weighting, decision, region close and result push.
`default_nettype none

module brd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brd_pkg::brd_sts_t sts_i,
  output brd_pkg::brd_cmd_t cmd_o
);
  import brd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WGT  = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_LEN  = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_MEAN = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_WGT;
        end
      end
      S_WGT: begin
        cmd_o.weigh = 1'b1;
        state_d     = S_DEC;
      end
      S_DEC: begin
        cmd_o.decide = 1'b1;
        state_d      = S_LEN;
      end
      S_LEN: begin
        cmd_o.len_calc = 1'b1;
        state_d        = S_CMP;
      end
      S_CMP: begin
        if (sts_i.close_pend && !sts_i.too_short) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd_o.mean = 1'b1;
        state_d    = S_UPD;
      end
      S_UPD: begin
        if (!(sts_i.held_valid && !sts_i.merge && sts_i.out_full)) begin
          cmd_o.update = 1'b1;
          state_d      = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (!sts_i.out_full) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");
`endif

endmodule

`default_nettype wire
